FILE: src/tkc_pkg.sv
package tkc_pkg;

    // input and output field widths
    localparam int EMF_W  = 23;
    localparam int TEMP_W = 20;

    // fixed-point layout of the horner datapath
    localparam int COEF_FRAC  = 16;
    localparam int U_FRAC     = 22;
    localparam int ACC_W      = 58;
    localparam int MAG_W      = ACC_W - 1;
    localparam int U_W        = EMF_W;
    localparam int LO_W       = 32;
    localparam int HI_W       = MAG_W - LO_W;
    localparam int LO_PROD_W  = LO_W + U_W;
    localparam int HI_PROD_W  = HI_W + U_W;
    localparam int OUT_FRAC_SHIFT = COEF_FRAC - 8;
    localparam int RND_W      = MAG_W + 1 - OUT_FRAC_SHIFT;

    localparam int NUM_STEPS  = 9;
    localparam int NUM_COEF   = NUM_STEPS + 1;

    localparam logic [RND_W-1:0] TEMP_POS_LIMIT = RND_W'(524287);
    localparam logic [RND_W-1:0] TEMP_NEG_LIMIT = RND_W'(524288);
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_VAL = TEMP_W'(524287);
    localparam logic signed [TEMP_W-1:0] TEMP_MIN_VAL = TEMP_W'(-524288);

    typedef logic signed [ACC_W-1:0] acc_t;

    // per-item control that travels with the accumulator
    typedef struct packed {
        logic           valid;
        logic           set_neg;
        logic [U_W-1:0] u_mag;
    } tkc_lane_t;

    // round(mant * 10^-exp10 * 2^(6j + 16)), ties away from zero, by long division
    function automatic acc_t scaled_coef(input int mant, input int exp10, input int j);
        logic [63:0]  den;
        logic [127:0] num;
        logic [127:0] q;
        logic [64:0]  r;
        logic [31:0]  mag;
        int           shift;
        den = 64'd1;
        for (int i = 0; i < exp10; i++)
        begin
            den = den * 64'd5;
        end
        mag   = (mant < 0) ? 32'(-mant) : 32'(mant);
        shift = 6 * j + COEF_FRAC - exp10;
        num   = 128'(mag) << shift;
        q     = '0;
        r     = '0;
        for (int i = 127; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= 65'(den))
            begin
                r    = r - 65'(den);
                q[i] = 1'b1;
            end
        end
        if ({r[63:0], 1'b0} >= 65'(den))
        begin
            q = q + 128'd1;
        end
        return (mant < 0) ? $signed(-ACC_W'(q)) : $signed(ACC_W'(q));
    endfunction

    // sub-zero set, padded with a zero top coefficient so both sets take nine steps
    localparam acc_t COEF_NEG [NUM_COEF] = '{
        scaled_coef(0, 0, 0),
        scaled_coef(25173462, 6, 1),
        scaled_coef(-11662878, 7, 2),
        scaled_coef(-10833638, 7, 3),
        scaled_coef(-89773540, 8, 4),
        scaled_coef(-37342377, 8, 5),
        scaled_coef(-86632643, 9, 6),
        scaled_coef(-10450598, 9, 7),
        scaled_coef(-51920577, 11, 8),
        scaled_coef(0, 0, 9)
    };

    localparam acc_t COEF_POS [NUM_COEF] = '{
        scaled_coef(0, 0, 0),
        scaled_coef(2508355, 5, 1),
        scaled_coef(7860106, 8, 2),
        scaled_coef(-2503131, 7, 3),
        scaled_coef(8315270, 8, 4),
        scaled_coef(-1228034, 8, 5),
        scaled_coef(9804036, 10, 6),
        scaled_coef(-4413030, 11, 7),
        scaled_coef(1057734, 12, 8),
        scaled_coef(-1052755, 14, 9)
    };

endpackage

FILE: src/tkc_emf_if.sv
interface tkc_emf_if import tkc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [EMF_W-1:0] emf_sample;

    modport source (output valid, output emf_sample, input ready);
    modport sink   (input valid, input emf_sample, output ready);
endinterface

FILE: src/tkc_temp_if.sv
interface tkc_temp_if import tkc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

FILE: src/tkc_horner_step.sv
module tkc_horner_step
    import tkc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  tkc_lane_t lane_in,
    input  acc_t      acc_in,
    input  acc_t      coef_pos,
    input  acc_t      coef_neg,
    output tkc_lane_t lane_out,
    output acc_t      acc_out
);

    // stage 1: magnitude of accumulator
    tkc_lane_t            s1_lane_reg;
    logic [MAG_W-1:0]     s1_mag_reg;
    logic                 s1_sign_reg;
    // stage 2: partial products
    tkc_lane_t            s2_lane_reg;
    logic [LO_PROD_W-1:0] s2_lo_reg;
    logic [HI_PROD_W-1:0] s2_hi_reg;
    logic                 s2_neg_reg;
    // stage 3: rounded product magnitude
    tkc_lane_t            s3_lane_reg;
    logic [ACC_W-1:0]     s3_m_reg;
    logic                 s3_neg_reg;
    // stage 4: accumulate coefficient
    tkc_lane_t            s4_lane_reg;
    acc_t                 s4_acc_reg;

    acc_t                 abs_acc;
    logic [LO_PROD_W:0]   lo_sum;
    logic [ACC_W-1:0]     m_next;
    acc_t                 coef_sel;
    acc_t                 acc_next;

    always_comb
    begin
        abs_acc  = acc_in[ACC_W-1] ? -acc_in : acc_in;
        lo_sum   = {1'b0, s2_lo_reg} + (LO_PROD_W + 1)'(1 << (U_FRAC - 1));
        m_next   = {s2_hi_reg, {(ACC_W - HI_PROD_W){1'b0}}}
                 + ACC_W'(lo_sum[LO_PROD_W:U_FRAC]);
        coef_sel = s3_lane_reg.set_neg ? coef_neg : coef_pos;
        acc_next = s3_neg_reg ? coef_sel - $signed(s3_m_reg) : coef_sel + $signed(s3_m_reg);
    end

    // lane control, valid bits cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_lane_reg <= '0;
            s2_lane_reg <= '0;
            s3_lane_reg <= '0;
            s4_lane_reg <= '0;
        end
        else if (adv)
        begin
            s1_lane_reg <= lane_in;
            s2_lane_reg <= s1_lane_reg;
            s3_lane_reg <= s2_lane_reg;
            s4_lane_reg <= s3_lane_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg          <= abs_acc[MAG_W-1:0];
            s1_sign_reg         <= acc_in[ACC_W-1];

            s2_lo_reg           <= s1_mag_reg[LO_W-1:0] * s1_lane_reg.u_mag;
            s2_hi_reg           <= s1_mag_reg[MAG_W-1:LO_W] * s1_lane_reg.u_mag;
            s2_neg_reg          <= s1_sign_reg ^ s1_lane_reg.set_neg;

            s3_m_reg            <= m_next;
            s3_neg_reg          <= s2_neg_reg;

            s4_acc_reg          <= acc_next;
        end
    end

    assign lane_out = s4_lane_reg;
    assign acc_out  = s4_acc_reg;

    // a valid item entering while advancing shows up in stage 1
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        adv && lane_in.valid |=> s1_lane_reg.valid)
        else $error("horner step dropped an entering item");

    // a stall freezes the result stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && s4_lane_reg.valid |=> s4_lane_reg.valid && $stable(s4_acc_reg))
        else $error("horner step result changed during stall");

    // zero voltage leaves only the coefficient of the positive set
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s4_lane_reg.valid && (s4_lane_reg.u_mag == '0) |-> s4_acc_reg == coef_pos)
        else $error("horner step wrong for zero voltage");

    // products of a zero magnitude are zero
    a_prod: assert property (@(posedge clk) disable iff (!rst_n)
        s2_lane_reg.valid && (s2_lane_reg.u_mag == '0) |-> (s2_lo_reg == '0) && (s2_hi_reg == '0))
        else $error("horner step product wrong for zero voltage");

endmodule

FILE: src/type_k_emf_to_temperature_core.sv
// type k thermocouple emf to temperature, its-90 inverse polynomial by horner pipeline
// stages: 2 entry, 9 x 4 horner, 3 output
// throughput: one transaction per cycle; each horner step is four stages
// (magnitude, split multiply, round, coefficient add); a stall freezes the whole pipe
// reset: rst_n asynchronous active low clears all valid bits and lane control; no datapath state
module type_k_emf_to_temperature_core
    import tkc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tkc_emf_if.sink           emf_in,
    tkc_temp_if.source        temp_out
);

    // global advance: the pipe moves unless the output register holds an untaken result
    logic adv;

    // entry stage 1: captured sample
    logic                    p1_valid_reg;
    logic signed [EMF_W-1:0] p1_emf_reg;

    // entry stage 2: magnitude of u, polynomial set and top coefficient
    tkc_lane_t               p2_lane_reg;
    acc_t                    p2_acc_reg;

    // lanes and accumulators between horner steps
    tkc_lane_t               lane [NUM_STEPS + 1];
    acc_t                    acc  [NUM_STEPS + 1];

    // output stage 1: magnitude and sign of final accumulator
    logic                    f1_valid_reg;
    logic [MAG_W-1:0]        f1_mag_reg;
    logic                    f1_sign_reg;
    // output stage 2: rounded to 8 fractional bits
    logic                    f2_valid_reg;
    logic [RND_W-1:0]        f2_rnd_reg;
    logic                    f2_sign_reg;
    // output stage 3: saturated result register
    logic                    f3_valid_reg;
    logic signed [TEMP_W-1:0] f3_temp_reg;

    logic [EMF_W-1:0]        u_mag_next;
    acc_t                    abs_final;
    logic [MAG_W:0]          rnd_sum;
    logic signed [TEMP_W-1:0] temp_next;

    assign adv          = !f3_valid_reg || temp_out.ready;
    assign emf_in.ready = adv;

    always_comb
    begin
        // two's complement magnitude; the most negative code maps to 2^22, still 23 bits
        u_mag_next = p1_emf_reg[EMF_W-1] ? EMF_W'(-p1_emf_reg) : EMF_W'(p1_emf_reg);
        abs_final  = acc[NUM_STEPS][ACC_W-1] ? -acc[NUM_STEPS] : acc[NUM_STEPS];
        // round half away from zero on the magnitude
        rnd_sum    = {1'b0, f1_mag_reg} + (MAG_W + 1)'(1 << (OUT_FRAC_SHIFT - 1));
        // saturate on magnitude, then apply the sign
        if (f2_sign_reg)
        begin
            temp_next = (f2_rnd_reg > TEMP_NEG_LIMIT) ? TEMP_MIN_VAL
                                                      : -$signed(f2_rnd_reg[TEMP_W-1:0]);
        end
        else
        begin
            temp_next = (f2_rnd_reg > TEMP_POS_LIMIT) ? TEMP_MAX_VAL
                                                      : $signed(f2_rnd_reg[TEMP_W-1:0]);
        end
    end

    // valid bits of entry and output stages, entry lane control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg      <= 1'b0;
            p2_lane_reg       <= '0;
            f1_valid_reg      <= 1'b0;
            f2_valid_reg      <= 1'b0;
            f3_valid_reg      <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg        <= emf_in.valid;
            p2_lane_reg.valid   <= p1_valid_reg;
            // negative voltage selects the sub-zero set, whose padded top term is zero
            p2_lane_reg.set_neg <= p1_emf_reg[EMF_W-1];
            p2_lane_reg.u_mag   <= u_mag_next;
            f1_valid_reg        <= lane[NUM_STEPS].valid;
            f2_valid_reg        <= f1_valid_reg;
            f3_valid_reg        <= f2_valid_reg;
        end
    end

    // payload of entry and output stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_emf_reg          <= emf_in.emf_sample;

            p2_acc_reg          <= p1_emf_reg[EMF_W-1] ? COEF_NEG[NUM_STEPS]
                                                       : COEF_POS[NUM_STEPS];

            f1_mag_reg          <= abs_final[MAG_W-1:0];
            f1_sign_reg         <= acc[NUM_STEPS][ACC_W-1];

            f2_rnd_reg          <= rnd_sum[MAG_W:OUT_FRAC_SHIFT];
            f2_sign_reg         <= f1_sign_reg;

            f3_temp_reg         <= temp_next;
        end
    end

    assign lane[0] = p2_lane_reg;
    assign acc[0]  = p2_acc_reg;

    // horner chain: step k folds in the coefficient of power 8 - k
    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_step
        tkc_horner_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .lane_in  (lane[k]),
            .acc_in   (acc[k]),
            .coef_pos (COEF_POS[NUM_STEPS - 1 - k]),
            .coef_neg (COEF_NEG[NUM_STEPS - 1 - k]),
            .lane_out (lane[k + 1]),
            .acc_out  (acc[k + 1])
        );
    end

    assign temp_out.valid       = f3_valid_reg;
    assign temp_out.temperature = f3_temp_reg;

    // an accepted sample is captured in the entry stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        emf_in.valid && emf_in.ready |=> p1_valid_reg)
        else $error("input transaction not captured");

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        temp_out.valid && !temp_out.ready |=> temp_out.valid && $stable(temp_out.temperature))
        else $error("result changed while waiting");

    // ready only drops while a result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !emf_in.ready |-> temp_out.valid && !temp_out.ready)
        else $error("input stalled without output backpressure");

endmodule

FILE: dv/type_k_emf_to_temperature_core_tb.sv
`timescale 1ns / 100ps

module type_k_emf_to_temperature_core_tb
    import tkc_pkg::*;
;

    // run guard, far above the slowest correct run (~1500 transactions with long gaps)
    localparam int CYCLE_LIMIT = 1000000;
    // settle window after the last result
    localparam int SETTLE_CYCLES = 60;

    // its-90 range ends in 2^-16 mV units (-5.891 mV and 20.644 mV)
    localparam int EMF_ITS_LOW  = -386073;
    localparam int EMF_ITS_HIGH = 1352925;
    localparam int EMF_MIN      = -4194304;
    localparam int EMF_MAX      = 4194303;

    localparam int TEMP_MIN = -524288;
    localparam int TEMP_MAX = 524287;

    logic clk;
    logic rst_n;

    tkc_emf_if  emf_bus ();
    tkc_temp_if temp_bus ();

    type_k_emf_to_temperature_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .emf_in   (emf_bus),
        .temp_out (temp_bus)
    );

    // scaled horner coefficients a_j = c_j * 64^j with 16 fractional bits
    longint subzero_coef [9];
    longint above_zero_coef [10];

    // temperatures predicted for accepted emf transactions, oldest first
    logic signed [TEMP_W-1:0] expected_temps [$];
    logic signed [TEMP_W-1:0] oldest_temp;

    int err_count;
    int cycle_count;

    // idling controls shared between the test tasks and the two sides
    bit emf_idle_on;
    bit temp_idle_on;
    int temp_hold;
    int temp_gap;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // decimal coefficient mant * 10^-exp10 scaled by 2^(6j + 16),
    // rounded to nearest, ties away from zero; long division by 5^exp10
    function automatic longint scale_coef(input longint mant, input int exp10, input int j);
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] quot;
        logic [63:0] rem;
        int          shift;
        den = 64'd1;
        for (int i = 0; i < exp10; i++)
        begin
            den = den * 64'd5;
        end
        mag   = (mant < 0) ? 64'(-mant) : 64'(mant);
        quot  = mag / den;
        rem   = mag % den;
        shift = 6 * j + 16 - exp10;
        for (int i = 0; i < shift; i++)
        begin
            quot = quot << 1;
            rem  = rem << 1;
            if (rem >= den)
            begin
                quot = quot + 64'd1;
                rem  = rem - den;
            end
        end
        if ((rem << 1) >= den)
        begin
            quot = quot + 64'd1;
        end
        return (mant < 0) ? -longint'(quot) : longint'(quot);
    endfunction

    task automatic load_coefs();
        // sub-zero set, ascending powers of x in mV
        subzero_coef[0] = scale_coef(0, 0, 0);
        subzero_coef[1] = scale_coef(25173462, 6, 1);
        subzero_coef[2] = scale_coef(-11662878, 7, 2);
        subzero_coef[3] = scale_coef(-10833638, 7, 3);
        subzero_coef[4] = scale_coef(-89773540, 8, 4);
        subzero_coef[5] = scale_coef(-37342377, 8, 5);
        subzero_coef[6] = scale_coef(-86632643, 9, 6);
        subzero_coef[7] = scale_coef(-10450598, 9, 7);
        subzero_coef[8] = scale_coef(-51920577, 11, 8);
        // 0..500 degC set
        above_zero_coef[0] = scale_coef(0, 0, 0);
        above_zero_coef[1] = scale_coef(2508355, 5, 1);
        above_zero_coef[2] = scale_coef(7860106, 8, 2);
        above_zero_coef[3] = scale_coef(-2503131, 7, 3);
        above_zero_coef[4] = scale_coef(8315270, 8, 4);
        above_zero_coef[5] = scale_coef(-1228034, 8, 5);
        above_zero_coef[6] = scale_coef(9804036, 10, 6);
        above_zero_coef[7] = scale_coef(-4413030, 11, 7);
        above_zero_coef[8] = scale_coef(1057734, 12, 8);
        above_zero_coef[9] = scale_coef(-1052755, 14, 9);
    endtask

    // acc * u / 2^22 on magnitudes, rounded half up, sign applied afterwards
    function automatic longint mul_round_u(input longint acc, input longint u);
        logic [127:0] prod;
        logic [63:0]  acc_mag;
        logic [63:0]  u_mag;
        acc_mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        u_mag   = (u < 0) ? 64'(-u) : 64'(u);
        prod    = {64'd0, acc_mag} * {64'd0, u_mag};
        prod    = (prod + (128'd1 << 21)) >> 22;
        return ((acc < 0) != (u < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic logic signed [TEMP_W-1:0] emf_to_temp(
        input logic signed [EMF_W-1:0] emf
    );
        longint      u;
        longint      acc;
        longint      temp;
        logic [63:0] mag;
        u = emf;
        // negative voltage takes the sub-zero set, zero and up the other one
        if (u < 0)
        begin
            acc = subzero_coef[8];
            for (int j = 7; j >= 0; j--)
            begin
                acc = mul_round_u(acc, u) + subzero_coef[j];
            end
        end
        else
        begin
            acc = above_zero_coef[9];
            for (int j = 8; j >= 0; j--)
            begin
                acc = mul_round_u(acc, u) + above_zero_coef[j];
            end
        end
        // drop to 8 fractional bits, ties away from zero
        mag  = (acc < 0) ? 64'(-acc) : 64'(acc);
        mag  = (mag + 64'd128) >> 8;
        temp = (acc < 0) ? -longint'(mag) : longint'(mag);
        if (temp < TEMP_MIN)
        begin
            temp = TEMP_MIN;
        end
        if (temp > TEMP_MAX)
        begin
            temp = TEMP_MAX;
        end
        return temp[TEMP_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back, sometimes a few cycles, rarely a long stretch
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        else if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // full range, the its-90 ranges, around zero, and near the field ends
    function automatic logic signed [EMF_W-1:0] random_emf();
        int roll;
        int val;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            val = int'($urandom_range(0, EMF_MAX - EMF_MIN)) + EMF_MIN;
        end
        else if (roll < 70)
        begin
            val = int'($urandom_range(0, EMF_ITS_HIGH - EMF_ITS_LOW)) + EMF_ITS_LOW;
        end
        else if (roll < 90)
        begin
            val = int'($urandom_range(0, 8192)) - 4096;
        end
        else if (roll < 95)
        begin
            val = EMF_MAX - int'($urandom_range(0, 255));
        end
        else
        begin
            val = EMF_MIN + int'($urandom_range(0, 255));
        end
        return EMF_W'(val);
    endfunction

    // offer one emf transaction and hold it until accepted; valid stays high
    // afterwards so the next call can go back to back without a bubble
    task automatic send_emf(input logic signed [EMF_W-1:0] sample);
        int gap;
        gap = emf_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            emf_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        emf_bus.valid      <= 1'b1;
        emf_bus.emf_sample <= sample;
        @(posedge clk);
        while (!emf_bus.ready)
        begin
            @(posedge clk);
        end
        // accepted at this edge
        expected_temps.push_back(emf_to_temp(sample));
    endtask

    // source goes quiet until the pipe has handed back everything
    task automatic wait_for_temps();
        emf_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_temps.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field ends, sign boundary, its-90 range ends, alternating bit patterns
    task automatic test_directed_points();
        int points [] = '{
            0, 1, -1, 2, -2, 128, -128, 65536, -65536, 327680, -131072,
            EMF_ITS_LOW, EMF_ITS_LOW - 1, EMF_ITS_HIGH, EMF_ITS_HIGH + 1,
            EMF_MAX, EMF_MIN, EMF_MAX - 1, EMF_MIN + 1,
            2796202, -2796203, 2097152, -2097152
        };
        foreach (points[i])
        begin
            send_emf(EMF_W'(points[i]));
        end
    endtask

    // random samples with random gaps on both sides
    task automatic test_random_mix(input int count);
        emf_idle_on  = 1'b1;
        temp_idle_on = 1'b1;
        repeat (count)
        begin
            send_emf(random_emf());
        end
    endtask

    // full rate, no idling on either side
    task automatic test_full_rate(input int count);
        emf_idle_on  = 1'b0;
        temp_idle_on = 1'b0;
        repeat (count)
        begin
            send_emf(random_emf());
        end
        emf_idle_on  = 1'b1;
        temp_idle_on = 1'b1;
    endtask

    // sink holds off long enough for the pipe to fill and stall the input,
    // while the source keeps offering transactions back to back
    task automatic test_output_backpressure(input int count);
        emf_idle_on = 1'b0;
        temp_hold   = 250;
        repeat (count)
        begin
            send_emf(random_emf());
        end
        emf_idle_on = 1'b1;
    endtask

    // source pauses until the pipe is empty, then resumes
    task automatic test_drain_pause(input int count);
        wait_for_temps();
        repeat (count)
        begin
            send_emf(random_emf());
        end
    endtask

    // ------------------------------------------------------------------
    // sink side: random ready, plus a long hold when a test asks for one
    // ------------------------------------------------------------------
    initial
    begin
        temp_bus.ready <= 1'b0;
        temp_gap = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (temp_hold > 0)
            begin
                temp_bus.ready <= 1'b0;
                temp_hold--;
            end
            else if (temp_gap > 0)
            begin
                temp_bus.ready <= 1'b0;
                temp_gap--;
            end
            else
            begin
                temp_bus.ready <= 1'b1;
                temp_gap = temp_idle_on ? pick_gap() : 0;
            end
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // result check against the oldest predicted temperature
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && temp_bus.valid && temp_bus.ready)
        begin
            if (expected_temps.size() == 0)
            begin
                $error("temperature: expected none, actual %0d", temp_bus.temperature);
                err_count++;
            end
            else
            begin
                oldest_temp = expected_temps.pop_front();
                if (temp_bus.temperature !== oldest_temp)
                begin
                    $error("temperature: expected %0d, actual %0d",
                           oldest_temp, temp_bus.temperature);
                    err_count++;
                end
            end
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        err_count          = 0;
        cycle_count        = 0;
        temp_hold          = 0;
        emf_idle_on        = 1'b1;
        temp_idle_on       = 1'b1;
        rst_n              <= 1'b0;
        emf_bus.valid      <= 1'b0;
        emf_bus.emf_sample <= '0;
        load_coefs();

        // reset held, then released once
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_points();
        test_random_mix(600);
        test_full_rate(150);
        test_output_backpressure(150);
        test_drain_pause(100);
        test_random_mix(400);

        // all stimulus accepted: let the pipe empty, then a settle window
        wait_for_temps();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
